FILE: hdl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 framed record check: shared package
// Types, constants and the CRC byte update shared by the front, the beat
// queue and the back end.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [8:0]  MIN_RECORD    = 9'd6;
	localparam logic [8:0]  HEADER_BYTES  = 9'd2;
	localparam logic [8:0]  COUNT_MAX     = 9'd511;
	localparam logic [7:0]  VERSION_RESET = 8'd1;

	// queue depth, a power of two
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_VERSION  = 3'd2,
		ST_OVERRUN  = 3'd3,
		ST_CRC      = 3'd4
	} status_t;

	// classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       crc_en;     // byte is covered by the CRC
		logic       rx_en;      // byte is part of the received CRC
		logic [1:0] rx_idx;     // byte lane of the received CRC
		logic       pay;        // payload byte
		logic       last;       // last byte of the record
		status_t    pre_status; // verdict without the CRC compare
		logic [7:0] plen;       // length byte as received
	} beat_t;

	// one result item
	typedef struct packed {
		logic       pay;
		logic [7:0] data;
		logic       last;
		status_t    status;
		logic [7:0] plen;
	} result_t;

	// reflected CRC-32 update over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/crc32_framed_record_check_top.sv
// ----------------------------------------------------------------------------
// CRC-32 framed record check: top level
// Checks records of version, length, payload and little-endian CRC-32.
// ----------------------------------------------------------------------------
// The block takes one record byte per clock when not full and can return one
// result per clock while pop is held and not empty; each byte is registered
// in the beat queue and its result in the result queue; the single-byte CRC
// update sets the clock rate. Payload bytes come out as they arrive and
// must be dropped unless the verdict on the last byte is ok; bytes after
// the CRC give no result unless last. expected_version is written with
// expected_version_we and should only change while no record is in flight.
module crc32_framed_record_check_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       verdict_valid,
	output logic [2:0] status,
	output logic [7:0] payload_length,
	input  logic       expected_version_we,
	input  logic [7:0] expected_version
);

	crcfr_pkg::beat_t   beat_in;
	crcfr_pkg::beat_t   beat_out;
	crcfr_pkg::result_t result;
	logic               beat_push;
	logic               beat_full;
	logic               beat_pop;
	logic               beat_empty;

	// classify incoming bytes
	crcfr_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.data_byte           (data_byte),
		.last_byte           (last_byte),
		.expected_version_we (expected_version_we),
		.expected_version    (expected_version),
		.beat_full           (beat_full),
		.beat_push           (beat_push),
		.beat                (beat_in)
	);

	// decouple front and back
	crcfr_beat_q u_beat_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (beat_push),
		.beat_in  (beat_in),
		.full     (beat_full),
		.pop      (beat_pop),
		.beat_out (beat_out),
		.empty    (beat_empty)
	);

	// run the CRC and queue results
	crcfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat_out),
		.beat_empty (beat_empty),
		.beat_pop   (beat_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign payload_valid  = result.pay;
	assign payload_byte   = result.data;
	assign verdict_valid  = result.last;
	assign status         = result.status;
	assign payload_length = result.plen;

	// every result carries a payload byte or a verdict
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (payload_valid || verdict_valid))
		else $error("result with neither payload nor verdict");

	// verdict fields are zero on payload-only results
	a_no_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !verdict_valid) |->
		(status == crcfr_pkg::ST_OK && payload_length == 8'd0))
		else $error("verdict fields set without a verdict");

	// payload byte is zero when no payload is carried
	a_no_payload_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !payload_valid) |-> (payload_byte == 8'd0))
		else $error("payload byte set without payload");

	// status code stays within the defined verdicts
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= crcfr_pkg::ST_CRC))
		else $error("undefined status code");

endmodule

FILE: hdl/crcfr_front.sv
// ----------------------------------------------------------------------------
// CRC-32 framed record check: front end
// Accepts record bytes, tracks position, version and length, classifies each
// byte and works out every verdict check that does not need the CRC.
// ----------------------------------------------------------------------------
module crcfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              expected_version_we,
	input  logic [7:0]        expected_version,
	input  logic              beat_full,
	output logic              beat_push,
	output crcfr_pkg::beat_t  beat
);

	logic [8:0] count_q;
	logic [7:0] version_q;
	logic [7:0] length_q;
	logic [7:0] exp_version_q;

	logic       is_ver;
	logic       is_len;
	logic       is_pay;
	logic       is_rx;
	logic [8:0] pay_end;
	logic [8:0] rx_end;
	logic [8:0] rx_off;
	logic [8:0] count_next;
	logic [7:0] version_new;
	logic [7:0] length_new;
	logic [8:0] need;
	crcfr_pkg::status_t pre;

	// stall whenever the beat queue is full
	assign full      = beat_full;
	assign beat_push = push && !beat_full;

	// classify the byte by its place in the record
	always_comb begin
		pay_end     = crcfr_pkg::HEADER_BYTES + {1'b0, length_q};
		rx_end      = crcfr_pkg::MIN_RECORD + {1'b0, length_q};
		rx_off      = count_q - pay_end;
		is_ver      = (count_q == 9'd0);
		is_len      = (count_q == 9'd1);
		is_pay      = !is_ver && !is_len && (count_q < pay_end);
		is_rx       = !is_ver && !is_len && !is_pay && (count_q < rx_end);
		count_next  = (count_q == crcfr_pkg::COUNT_MAX) ? count_q : count_q + 9'd1;
		version_new = is_ver ? data_byte : version_q;
		length_new  = is_len ? data_byte : length_q;
		need        = {1'b0, length_new} + crcfr_pkg::MIN_RECORD;
		if (count_next < crcfr_pkg::MIN_RECORD) begin
			pre = crcfr_pkg::ST_SHORT;
		end else if (version_new != exp_version_q) begin
			pre = crcfr_pkg::ST_VERSION;
		end else if (need > count_next) begin
			pre = crcfr_pkg::ST_OVERRUN;
		end else begin
			pre = crcfr_pkg::ST_OK;
		end
	end

	// build the beat for the back end
	always_comb begin
		beat.data       = data_byte;
		beat.crc_en     = is_ver || is_len || is_pay;
		beat.rx_en      = is_rx;
		beat.rx_idx     = rx_off[1:0];
		beat.pay        = is_pay;
		beat.last       = last_byte;
		beat.pre_status = pre;
		beat.plen       = length_new;
	end

	// hold record state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= 9'd0;
			version_q     <= 8'd0;
			length_q      <= 8'd0;
			exp_version_q <= crcfr_pkg::VERSION_RESET;
		end else begin
			if (expected_version_we) begin
				exp_version_q <= expected_version;
			end
			if (beat_push) begin
				if (last_byte) begin
					count_q   <= 9'd0;
					version_q <= 8'd0;
					length_q  <= 8'd0;
				end else begin
					count_q   <= count_next;
					version_q <= version_new;
					length_q  <= length_new;
				end
			end
		end
	end

endmodule

FILE: hdl/crcfr_beat_q.sv
// ----------------------------------------------------------------------------
// CRC-32 framed record check: beat queue
// Short queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module crcfr_beat_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crcfr_pkg::beat_t  beat_in,
	output logic              full,
	input  logic              pop,
	output crcfr_pkg::beat_t  beat_out,
	output logic              empty
);

	crcfr_pkg::beat_t          mem [crcfr_pkg::Q_DEPTH];
	logic [crcfr_pkg::Q_AW-1:0] wr_ptr_q;
	logic [crcfr_pkg::Q_AW-1:0] rd_ptr_q;
	logic [crcfr_pkg::Q_AW:0]   count_q;

	assign full     = (count_q == (crcfr_pkg::Q_AW+1)'(crcfr_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign beat_out = mem[rd_ptr_q];

	// store the beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= beat_in;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/crcfr_back.sv
// ----------------------------------------------------------------------------
// CRC-32 framed record check: back end
// Runs the CRC over the covered bytes, assembles the received CRC, settles
// the verdict and queues result items for the output side.
// ----------------------------------------------------------------------------
module crcfr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  crcfr_pkg::beat_t  beat,
	input  logic              beat_empty,
	output logic              beat_pop,
	output logic              empty,
	input  logic              pop,
	output crcfr_pkg::result_t result
);

	logic [31:0] crc_q;
	logic [31:0] rx_q;

	crcfr_pkg::result_t         mem [crcfr_pkg::Q_DEPTH];
	logic [crcfr_pkg::Q_AW-1:0] wr_ptr_q;
	logic [crcfr_pkg::Q_AW-1:0] rd_ptr_q;
	logic [crcfr_pkg::Q_AW:0]   count_q;

	logic        oq_full;
	logic        has_result;
	logic        res_push;
	logic        res_pop;
	logic [31:0] crc_next;
	logic [31:0] rx_next;
	logic [31:0] rx_lane;
	crcfr_pkg::result_t res_new;

	assign oq_full    = (count_q == (crcfr_pkg::Q_AW+1)'(crcfr_pkg::Q_DEPTH));
	assign empty      = (count_q == '0);
	assign result     = mem[rd_ptr_q];
	assign res_pop    = pop && !empty;
	assign has_result = beat.pay || beat.last;
	assign beat_pop   = !beat_empty && (!has_result || !oq_full);
	assign res_push   = beat_pop && has_result;

	// update CRC and received CRC, then settle the verdict
	always_comb begin
		crc_next = beat.crc_en ? crcfr_pkg::crc_byte(crc_q, beat.data) : crc_q;
		rx_lane  = {24'd0, beat.data} << {beat.rx_idx, 3'b000};
		rx_next  = beat.rx_en ? (rx_q | rx_lane) : rx_q;
		res_new.pay  = beat.pay;
		res_new.data = beat.pay ? beat.data : 8'd0;
		res_new.last = beat.last;
		res_new.plen = beat.last ? beat.plen : 8'd0;
		if (!beat.last) begin
			res_new.status = crcfr_pkg::ST_OK;
		end else if (beat.pre_status != crcfr_pkg::ST_OK) begin
			res_new.status = beat.pre_status;
		end else if (~crc_next != rx_next) begin
			res_new.status = crcfr_pkg::ST_CRC;
		end else begin
			res_new.status = crcfr_pkg::ST_OK;
		end
	end

	// store the result
	always_ff @(posedge clk) begin
		if (res_push) begin
			mem[wr_ptr_q] <= res_new;
		end
	end

	// hold CRC state; restart after the last byte; advance the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= crcfr_pkg::CRC_INIT;
			rx_q     <= 32'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (beat_pop) begin
				if (beat.last) begin
					crc_q <= crcfr_pkg::CRC_INIT;
					rx_q  <= 32'd0;
				end else begin
					crc_q <= crc_next;
					rx_q  <= rx_next;
				end
			end
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({res_push, res_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
